// ----- hdl/sadbm_pkg.sv -----
// Shared widths, constants and types for the RGB tile SAD best-match search.
package sadbm_pkg;

    // Tile geometry
    localparam int TILE_WIDTH  = 16;
    localparam int TILE_HEIGHT = 16;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int POS_W      = 12;
    localparam int SAD_W      = 18;
    localparam int PIX_SUM_W  = PIX_W + 2;

    // Saturation ceiling of the accumulator
    localparam logic [SAD_W-1:0] SAD_LIMIT = {SAD_W{1'b1}};

    // Sum above any real tile sum; clamped to the accumulator range
    localparam longint NO_MATCH_RAW = longint'(TILE_WIDTH) * longint'(TILE_HEIGHT)
                                      * 765 + 1;
    localparam logic [SAD_W-1:0] NO_MATCH =
        (NO_MATCH_RAW > longint'(SAD_LIMIT)) ? SAD_LIMIT : SAD_W'(NO_MATCH_RAW);

    // Position and markers of one pixel pair, carried alongside the lane results
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             tile_end;
        logic             search_end;
    } t_ctrl;

endpackage

// ----- hdl/sadbm_if.sv -----
// Valid/ready channels for pixel pairs in and best-match results out.
interface sadbm_in_if;
    logic                        valid;
    logic                        ready;
    logic [sadbm_pkg::PIX_W-1:0] target_red;
    logic [sadbm_pkg::PIX_W-1:0] target_green;
    logic [sadbm_pkg::PIX_W-1:0] target_blue;
    logic [sadbm_pkg::PIX_W-1:0] cand_red;
    logic [sadbm_pkg::PIX_W-1:0] cand_green;
    logic [sadbm_pkg::PIX_W-1:0] cand_blue;
    logic [sadbm_pkg::POS_W-1:0] cand_row;
    logic [sadbm_pkg::POS_W-1:0] cand_col;
    logic                        tile_end;
    logic                        search_end;

    modport source (
        output valid, target_red, target_green, target_blue,
               cand_red, cand_green, cand_blue, cand_row, cand_col,
               tile_end, search_end,
        input  ready
    );
    modport sink (
        input  valid, target_red, target_green, target_blue,
               cand_red, cand_green, cand_blue, cand_row, cand_col,
               tile_end, search_end,
        output ready
    );
endinterface

interface sadbm_out_if;
    logic                        valid;
    logic                        ready;
    logic [sadbm_pkg::POS_W-1:0] best_row;
    logic [sadbm_pkg::POS_W-1:0] best_col;
    logic [sadbm_pkg::SAD_W-1:0] best_sad;

    modport source (
        output valid, best_row, best_col, best_sad,
        input  ready
    );
    modport sink (
        input  valid, best_row, best_col, best_sad,
        output ready
    );
endinterface

// ----- hdl/sadbm_lane.sv -----
// One color lane: registered absolute difference of a target and a candidate byte.
module sadbm_lane (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [sadbm_pkg::PIX_W-1:0] i_target,
    input  logic [sadbm_pkg::PIX_W-1:0] i_cand,
    output logic [sadbm_pkg::PIX_W-1:0] o_diff
);

    logic [sadbm_pkg::PIX_W-1:0] r_diff;
    logic [sadbm_pkg::PIX_W-1:0] n_diff;

    // Subtract the smaller byte from the larger
    always_comb begin
        if (i_target > i_cand) begin
            n_diff = i_target - i_cand;
        end else begin
            n_diff = i_cand - i_target;
        end
    end

    // Capture on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_diff <= n_diff;
        end
    end

    assign o_diff = r_diff;

endmodule

// ----- hdl/sadbm_merge.sv -----
// Merge stage: sums the lane differences, accumulates per tile, keeps the best
// candidate and holds the result register.
module sadbm_merge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [sadbm_pkg::PIX_W-1:0] i_diff_red,
    input  logic [sadbm_pkg::PIX_W-1:0] i_diff_green,
    input  logic [sadbm_pkg::PIX_W-1:0] i_diff_blue,
    input  sadbm_pkg::t_ctrl            i_ctrl,
    output logic                        o_free,
    sadbm_out_if.source                 o_res
);

    logic [sadbm_pkg::SAD_W-1:0]     r_running;
    logic [sadbm_pkg::SAD_W-1:0]     r_min_sad;
    logic [sadbm_pkg::POS_W-1:0]     r_min_row;
    logic [sadbm_pkg::POS_W-1:0]     r_min_col;
    logic                            r_out_vld;
    logic [sadbm_pkg::POS_W-1:0]     r_best_row;
    logic [sadbm_pkg::POS_W-1:0]     r_best_col;
    logic [sadbm_pkg::SAD_W-1:0]     r_best_sad;

    logic [sadbm_pkg::PIX_SUM_W-1:0] pix_sum;
    logic [sadbm_pkg::SAD_W:0]       wide_sum;
    logic [sadbm_pkg::SAD_W-1:0]     tile_sum;
    logic                            better;
    logic [sadbm_pkg::SAD_W-1:0]     n_min_sad;
    logic [sadbm_pkg::POS_W-1:0]     n_min_row;
    logic [sadbm_pkg::POS_W-1:0]     n_min_col;

    // Combine the three lanes and add to the running sum, saturating
    always_comb begin
        pix_sum  = sadbm_pkg::PIX_SUM_W'(i_diff_red)
                 + sadbm_pkg::PIX_SUM_W'(i_diff_green)
                 + sadbm_pkg::PIX_SUM_W'(i_diff_blue);
        wide_sum = {1'b0, r_running} + (sadbm_pkg::SAD_W + 1)'(pix_sum);
        if (wide_sum > {1'b0, sadbm_pkg::SAD_LIMIT}) begin
            tile_sum = sadbm_pkg::SAD_LIMIT;
        end else begin
            tile_sum = wide_sum[sadbm_pkg::SAD_W-1:0];
        end
    end

    // Compare at tile end; a tie keeps the earlier candidate
    always_comb begin
        better    = i_ctrl.tile_end && (tile_sum < r_min_sad);
        n_min_sad = better ? tile_sum   : r_min_sad;
        n_min_row = better ? i_ctrl.row : r_min_row;
        n_min_col = better ? i_ctrl.col : r_min_col;
    end

    // Advance the search state on each taken pair; restart after a search end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_min_sad <= sadbm_pkg::NO_MATCH;
            r_min_row <= '0;
            r_min_col <= '0;
        end else if (i_take) begin
            if (i_ctrl.search_end) begin
                r_running <= '0;
                r_min_sad <= sadbm_pkg::NO_MATCH;
                r_min_row <= '0;
                r_min_col <= '0;
            end else begin
                r_running <= i_ctrl.tile_end ? '0 : tile_sum;
                r_min_sad <= n_min_sad;
                r_min_row <= n_min_row;
                r_min_col <= n_min_col;
            end
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_take && i_ctrl.search_end) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_ctrl.search_end) begin
            r_best_row <= n_min_row;
            r_best_col <= n_min_col;
            r_best_sad <= n_min_sad;
        end
    end

    assign o_free         = !r_out_vld || o_res.ready;
    assign o_res.valid    = r_out_vld;
    assign o_res.best_row = r_best_row;
    assign o_res.best_col = r_best_col;
    assign o_res.best_sad = r_best_sad;

endmodule

// ----- hdl/rgb_block_sad_best_match_core.sv -----
// Top level of the RGB tile SAD best-match search: lanes, lane register and merge.
//
//  Channel   Dir  Carries                                       Transfer
//  i_pix     in   target/cand RGB, cand_row/col, tile/search    valid & ready
//  o_best    out  best_row, best_col, best_sad                  valid & ready
//
// One pixel pair is taken every cycle unless i_pix stalls; the red, green and blue lanes register
// their differences, and the merge stage accumulates and compares on the registered differences.
// A result is held in the merge result register once the search-end pair leaves the lane register.
// i_rst_n is synchronous, active low; it clears the search and empties the stages.
// i_pix stalls only when a search-end pair waits behind an untaken result.
module rgb_block_sad_best_match_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sadbm_in_if.sink    i_pix,
    sadbm_out_if.source o_best
);

    logic                        r_s1_vld;
    sadbm_pkg::t_ctrl            r_s1_ctrl;

    logic                        load;
    logic                        s1_take;
    logic                        out_free;
    logic [sadbm_pkg::PIX_W-1:0] diff_red;
    logic [sadbm_pkg::PIX_W-1:0] diff_green;
    logic [sadbm_pkg::PIX_W-1:0] diff_blue;

    // Pass the lane stage on unless a result would overrun the output register
    assign s1_take     = r_s1_vld && (!r_s1_ctrl.search_end || out_free);
    assign i_pix.ready = !r_s1_vld || s1_take;
    assign load        = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (load) begin
            r_s1_vld <= 1'b1;
        end else if (s1_take) begin
            r_s1_vld <= 1'b0;
        end
    end

    // Capture position and markers alongside the lane results
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_ctrl.row        <= i_pix.cand_row;
            r_s1_ctrl.col        <= i_pix.cand_col;
            r_s1_ctrl.tile_end   <= i_pix.tile_end;
            r_s1_ctrl.search_end <= i_pix.search_end;
        end
    end

    sadbm_lane u_lane_red (
        .i_clk    (i_clk),
        .i_load   (load),
        .i_target (i_pix.target_red),
        .i_cand   (i_pix.cand_red),
        .o_diff   (diff_red)
    );

    sadbm_lane u_lane_green (
        .i_clk    (i_clk),
        .i_load   (load),
        .i_target (i_pix.target_green),
        .i_cand   (i_pix.cand_green),
        .o_diff   (diff_green)
    );

    sadbm_lane u_lane_blue (
        .i_clk    (i_clk),
        .i_load   (load),
        .i_target (i_pix.target_blue),
        .i_cand   (i_pix.cand_blue),
        .o_diff   (diff_blue)
    );

    sadbm_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (s1_take),
        .i_diff_red   (diff_red),
        .i_diff_green (diff_green),
        .i_diff_blue  (diff_blue),
        .i_ctrl       (r_s1_ctrl),
        .o_free       (out_free),
        .o_res        (o_best)
    );

endmodule

// ----- tb/sv/sadbm_match_checker.sv -----
// Checker for the SAD best-match search: tracks pixel-pair transfers, predicts and compares results.
module sadbm_match_checker
    import sadbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sadbm_in_if         i_pix,
    sadbm_out_if        i_best,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [SAD_W-1:0] sad;
    } match_t;

    // Best matches predicted but not yet seen on the output
    match_t best_matches[$];

    // Predicted search state
    logic [SAD_W-1:0] tile_sad;
    logic [SAD_W-1:0] lead_sad;
    logic [POS_W-1:0] lead_row;
    logic [POS_W-1:0] lead_col;

    int fails   = 0;
    int results = 0;
    int pending = 0;

    assign o_fail_count   = fails;
    assign o_result_count = results;
    assign o_pending      = pending;

    function automatic logic [PIX_W-1:0] chan_gap(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic restart_search();
        tile_sad = '0;
        lead_sad = NO_MATCH;
        lead_row = '0;
        lead_col = '0;
    endtask

    // Accumulate one pixel pair; close the tile and the search where marked
    task automatic absorb_pair();
        logic [SAD_W:0] total;
        total = {1'b0, tile_sad}
              + chan_gap(i_pix.target_red,   i_pix.cand_red)
              + chan_gap(i_pix.target_green, i_pix.cand_green)
              + chan_gap(i_pix.target_blue,  i_pix.cand_blue);
        // saturate the accumulator
        if (total > {1'b0, SAD_LIMIT}) begin
            total = {1'b0, SAD_LIMIT};
        end
        if (i_pix.tile_end) begin
            // strictly smaller only, so the earlier tile keeps a tie
            if (total[SAD_W-1:0] < lead_sad) begin
                lead_sad = total[SAD_W-1:0];
                lead_row = i_pix.cand_row;
                lead_col = i_pix.cand_col;
            end
            tile_sad = '0;
        end else begin
            tile_sad = total[SAD_W-1:0];
        end
        // a search end drops any unfinished tile
        if (i_pix.search_end) begin
            best_matches.push_back(match_t'{row: lead_row, col: lead_col, sad: lead_sad});
            restart_search();
        end
    endtask

    // Compare one output transfer with the oldest prediction
    task automatic check_match();
        match_t want;
        if (best_matches.size() == 0) begin
            $error("unexpected result: best_row %0d best_col %0d best_sad %0d",
                   i_best.best_row, i_best.best_col, i_best.best_sad);
            fails++;
        end else begin
            want = best_matches.pop_front();
            results++;
            if (i_best.best_row !== want.row) begin
                $error("best_row: expected %0d, actual %0d", want.row, i_best.best_row);
                fails++;
            end
            if (i_best.best_col !== want.col) begin
                $error("best_col: expected %0d, actual %0d", want.col, i_best.best_col);
                fails++;
            end
            if (i_best.best_sad !== want.sad) begin
                $error("best_sad: expected %0d, actual %0d", want.sad, i_best.best_sad);
                fails++;
            end
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_search();
            best_matches.delete();
        end else begin
            if (i_best.valid && i_best.ready) begin
                check_match();
            end
            if (i_pix.valid && i_pix.ready) begin
                absorb_pair();
            end
        end
        pending = best_matches.size();
    end

endmodule

// ----- tb/sv/rgb_block_sad_best_match_core_tb.sv -----
// Top of the SAD best-match testbench: clock, reset, pixel-pair stimulus, result sink and verdict.
module rgb_block_sad_best_match_core_tb;
    import sadbm_pkg::*;

    typedef enum int {PIX_RANDOM, PIX_EQUAL, PIX_MAX, PIX_NEAR} pix_mode_e;

    logic clk;
    logic rst_n;

    sadbm_in_if  pix_if();
    sadbm_out_if best_if();

    int fail_count;
    int pending_count;
    int result_count;

    int pairs_sent    = 0;
    int searches_sent = 0;
    int sat_tiles     = 0;
    int src_idle_pct  = 28;
    int snk_stall_pct = 52;

    rgb_block_sad_best_match_core DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_if),
        .o_best  (best_if)
    );

    sadbm_match_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_pix          (pix_if),
        .i_best         (best_if),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_result_count (result_count)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    // Stall the result channel at random
    initial begin
        best_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            best_if.ready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Offer one pixel pair, idling first at random, and hold it until transfer
    task automatic send_pair(input logic [PIX_W-1:0] t_r, t_g, t_b, c_r, c_g, c_b,
                             input logic [POS_W-1:0] row, col,
                             input logic te, se);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid = 1'b0;
            @(negedge clk);
        end
        pix_if.target_red   = t_r;
        pix_if.target_green = t_g;
        pix_if.target_blue  = t_b;
        pix_if.cand_red     = c_r;
        pix_if.cand_green   = c_g;
        pix_if.cand_blue    = c_b;
        pix_if.cand_row     = row;
        pix_if.cand_col     = col;
        pix_if.tile_end     = te;
        pix_if.search_end   = se;
        pix_if.valid        = 1'b1;
        @(posedge clk);
        while (!pix_if.ready) @(posedge clk);
        pairs_sent++;
        if (se) searches_sent++;
    endtask

    // Stream one candidate tile; close it and/or the search on its last pair
    task automatic send_tile(input logic [POS_W-1:0] row, col, input int len,
                             input pix_mode_e mode, input logic close_tile,
                             input logic close_search);
        logic [PIX_W-1:0] tpix [3];
        logic [PIX_W-1:0] cpix [3];
        for (int i = 0; i < len; i++) begin
            for (int ch = 0; ch < 3; ch++) begin
                tpix[ch] = PIX_W'($urandom);
                case (mode)
                    PIX_RANDOM: cpix[ch] = PIX_W'($urandom);
                    PIX_EQUAL:  cpix[ch] = tpix[ch];
                    PIX_MAX: begin
                        tpix[ch] = $urandom_range(1) ? 8'hFF : 8'h00;
                        cpix[ch] = ~tpix[ch];
                    end
                    default:    cpix[ch] = tpix[ch] ^ PIX_W'($urandom_range(3));
                endcase
            end
            send_pair(tpix[0], tpix[1], tpix[2], cpix[0], cpix[1], cpix[2], row, col,
                      close_tile && (i == len - 1), close_search && (i == len - 1));
        end
    endtask

    // Fully random pairs with stray tile ends; the last one ends the search
    task automatic send_noise(input int len);
        for (int i = 0; i < len; i++) begin
            send_pair(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                      PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                      POS_W'($urandom), POS_W'($urandom),
                      $urandom_range(99) < 30, i == len - 1);
        end
    endtask

    // One search: random noise, or a few tiles, mostly short, sometimes cut by a search end mid-tile
    task automatic run_search(input bit force_sat);
        int n_tiles;
        int len;
        int pick;
        bit tail;
        pix_mode_e mode;
        if (!force_sat && $urandom_range(99) < 12) begin
            send_noise($urandom_range(1, 30));
        end else begin
            n_tiles = $urandom_range(0, 5);
            if (force_sat && n_tiles == 0) n_tiles = 1;
            tail = (n_tiles == 0) || ($urandom_range(99) < 20);
            for (int t = 0; t < n_tiles; t++) begin
                pick = $urandom_range(999);
                mode = pix_mode_e'($urandom_range(3));
                if ((force_sat && t == 0) || pick < 5) begin
                    // long enough at full difference to saturate the sum
                    len  = $urandom_range(345, 360);
                    mode = PIX_MAX;
                    sat_tiles++;
                end else if (pick < 25) begin
                    len = TILE_WIDTH * TILE_HEIGHT;
                end else begin
                    len = $urandom_range(1, 16);
                end
                send_tile(POS_W'($urandom), POS_W'($urandom), len, mode, 1'b1,
                          !tail && (t == n_tiles - 1));
            end
            if (tail) begin
                send_tile(POS_W'($urandom), POS_W'($urandom), $urandom_range(1, 8),
                          pix_mode_e'($urandom_range(3)), 1'b0, 1'b1);
            end
        end
    endtask

    initial begin
        int random_start;
        rst_n                = 1'b0;
        pix_if.valid         = 1'b0;
        pix_if.target_red    = '0;
        pix_if.target_green  = '0;
        pix_if.target_blue   = '0;
        pix_if.cand_red      = '0;
        pix_if.cand_green    = '0;
        pix_if.cand_blue     = '0;
        pix_if.cand_row      = '0;
        pix_if.cand_col      = '0;
        pix_if.tile_end      = 1'b0;
        pix_if.search_end    = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Full-scale differences both ways at extreme positions; the tie keeps the first
        send_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 12'hFFF, 12'hFFF, 1'b1, 1'b0);
        send_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 12'h000, 12'h000, 1'b1, 1'b0);
        // search end without tile end drops the partial tile
        send_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 12'h000, 12'h000, 1'b0, 1'b1);
        // empty search reports the no-match sum
        send_pair(8'd17, 8'd3, 8'd200, 8'd90, 8'd0, 8'd1, 12'd3, 12'd3, 1'b0, 1'b1);
        // zero-sum tie, then a partial tile cut by the search end
        send_pair(8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 12'd12, 12'd34, 1'b1, 1'b0);
        send_pair(8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 8'd200, 12'd56, 12'd78, 1'b1, 1'b0);
        send_pair(8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd99, 12'd99, 1'b0, 1'b0);
        send_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd99, 12'd99, 1'b0, 1'b1);
        // strictly smaller later tiles win; tile end together with search end
        send_pair(8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 12'd1, 12'd1, 1'b0, 1'b0);
        send_pair(8'd0, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0, 12'd1, 12'd1, 1'b1, 1'b0);
        send_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd14, 12'd2, 12'd2, 1'b1, 1'b0);
        send_pair(8'd128, 8'd128, 8'd128, 8'd127, 8'd127, 8'd127, 12'd2048, 12'd1024,
                  1'b1, 1'b1);
        // alternating bit patterns on every field
        send_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 12'hAAA, 12'h555, 1'b1, 1'b0);
        send_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 12'h555, 12'hAAA, 1'b1, 1'b1);
        // position comes from the tile-end pair, not the first pair of the tile
        send_pair(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 12'd7, 12'd7, 1'b0, 1'b0);
        send_pair(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 12'd8, 12'd9, 1'b1, 1'b1);

        // Random searches; move through the idle/stall mixes by thirds
        random_start = pairs_sent;
        run_search(1'b1);
        while (pairs_sent < random_start + 1750 || searches_sent < 48) begin
            if (src_idle_pct == 28 && pairs_sent >= random_start + 583) begin
                src_idle_pct  = 52;
                snk_stall_pct = 28;
            end else if (src_idle_pct == 52 && pairs_sent >= random_start + 1166) begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            run_search(1'b0);
        end
        @(negedge clk);
        pix_if.valid = 1'b0;

        // Drain outstanding results, then allow the pipeline to settle
        for (int n = 0; n < 2000 && pending_count != 0; n++) @(negedge clk);
        repeat (6) @(negedge clk);
        if (pending_count != 0) begin
            $error("%0d predicted results never arrived", pending_count);
        end

        $display("Sent %0d pixel pairs in %0d searches (%0d saturating tiles); %0d results checked.",
                 pairs_sent, searches_sent, sat_tiles, result_count);
        $display("Covered ties, empty searches, mid-tile search ends and three idle/stall mixes.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
